// ===== design/picp_pkg.sv =====
// Shared types, constants and codes for the point-in-convex-polygon core.
`timescale 1ns / 1ps

package picp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;
    localparam int COUNT_WIDTH  = 7;
    localparam int SLOT_WIDTH   = 6;
    localparam int ADDR_WIDTH   = $clog2(MAX_VERTICES);
    // Wide enough to hold the vertex count plus one, the final read index.
    localparam int NUM_WIDTH    = $clog2(MAX_VERTICES + 2);
    localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic neg;
    } edge_res_t;

endpackage

// ===== design/point_in_convex_polygon_core.sv =====
// Top level: vertex store, edge sequencer and result register.
// A load beat gives no result; the next beat can follow at once.
// A query over n stored vertices (n >= 2) reads one vertex and tests one edge per cycle; its
// result is loaded in the done state, and the next beat is taken once that result is loaded.
// A count of zero or one skips the edge walk and answers as inside.
// Reset clears the vertex count and all control state; the vertex store is undefined until loaded.
`timescale 1ns / 1ps

module point_in_convex_polygon_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    mode,
    input  logic [picp_pkg::SLOT_WIDTH-1:0]         slot,
    input  logic signed [picp_pkg::COORD_WIDTH-1:0] coord_x,
    input  logic signed [picp_pkg::COORD_WIDTH-1:0] coord_y,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    inside_res,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [picp_pkg::COUNT_WIDTH-1:0]        vertex_count
);

    localparam int AW = picp_pkg::ADDR_WIDTH;
    localparam int NW = picp_pkg::NUM_WIDTH;

    picp_pkg::state_t    state_reg, state_next;
    logic [picp_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [NW-1:0]       n_sat;
    logic [NW-1:0]       n_reg;
    logic [NW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                rd_issue;
    logic [AW-1:0]       rd_addr;
    logic                rd_vld_reg, rd_first_reg, rd_last_reg;
    picp_pkg::vertex_t   rd_data_reg;
    picp_pkg::vertex_t   prev_reg;
    logic signed [picp_pkg::COORD_WIDTH-1:0] px_reg, py_reg;
    logic                inside_acc_reg;
    logic                out_valid_reg;
    logic                inside_res_reg;
    logic                in_accept;
    logic                load_accept;
    logic                query_accept;
    logic                short_query;
    logic                out_load;
    logic                slot_ok;
    logic [AW-1:0]       wr_addr;
    picp_pkg::edge_ctl_t edge_ctl;
    picp_pkg::edge_res_t edge_res;

    picp_pkg::vertex_t   vertex_mem [picp_pkg::MAX_VERTICES];

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    always_comb
    begin
        if (32'(count_reg) > picp_pkg::MAX_VERTICES)
            n_sat = NW'(picp_pkg::MAX_VERTICES);
        else
            n_sat = NW'(count_reg);
    end

    assign in_accept    = in_valid && !in_stall;
    assign load_accept  = in_accept && (mode == picp_pkg::MODE_LOAD);
    assign query_accept = in_accept && (mode == picp_pkg::MODE_QUERY);
    // With fewer than two vertices no edge can give a negative sign.
    assign short_query  = (n_sat <= NW'(1));
    assign slot_ok      = (32'(slot) < picp_pkg::MAX_VERTICES);
    assign wr_addr      = AW'(slot);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            picp_pkg::ST_IDLE:
            begin
                if (query_accept)
                    state_next = short_query ? picp_pkg::ST_DONE : picp_pkg::ST_RUN;
            end
            picp_pkg::ST_RUN:
            begin
                if (edge_res.valid && edge_res.last)
                    state_next = picp_pkg::ST_DONE;
            end
            picp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = picp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = picp_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        in_stall    = 1'b1;
        rd_issue    = 1'b0;
        out_load    = 1'b0;
        rd_cnt_next = rd_cnt_reg;
        case (state_reg)
            picp_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                rd_cnt_next = '0;
            end
            picp_pkg::ST_RUN:
            begin
                rd_issue = (rd_cnt_reg <= n_reg);
                if (rd_issue)
                    rd_cnt_next = rd_cnt_reg + NW'(1);
            end
            picp_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // The read after the last vertex wraps to slot zero to close the polygon.
    assign rd_addr = (rd_cnt_reg == n_reg) ? '0 : rd_cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (load_accept && slot_ok)
            vertex_mem[wr_addr] <= '{x: coord_x, y: coord_y};
        if (rd_issue)
            rd_data_reg <= vertex_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= picp_pkg::ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            rd_cnt_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            inside_acc_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_vld_reg   <= rd_issue;
            rd_first_reg <= rd_issue && (rd_cnt_reg == '0);
            rd_last_reg  <= rd_issue && (rd_cnt_reg == n_reg);
            if (cfg_valid && cfg_ready)
                count_reg <= vertex_count;
            if (query_accept)
            begin
                n_reg          <= n_sat;
                inside_acc_reg <= 1'b1;
            end
            else if (edge_res.valid && edge_res.neg)
                inside_acc_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_vld_reg)
            prev_reg <= rd_data_reg;
        if (out_load)
            inside_res_reg <= inside_acc_reg;
    end

    assign edge_ctl.valid = rd_vld_reg && !rd_first_reg;
    assign edge_ctl.last  = rd_last_reg;

    picp_edge_unit u_edge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (edge_ctl),
        .vert_a  (prev_reg),
        .vert_b  (rd_data_reg),
        .point_x (px_reg),
        .point_y (py_reg),
        .res     (edge_res)
    );

    // Edge results only arrive while a query walks its edges.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_res.valid |-> state_reg == picp_pkg::ST_RUN)
        else $error("edge result outside a running query");

    // A new result is only presented after the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == picp_pkg::ST_DONE)
        else $error("result presented without a finished query");

    // The read counter never goes beyond one past the wrap read.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == picp_pkg::ST_RUN |-> rd_cnt_reg <= n_reg + NW'(1))
        else $error("read counter overran the vertex count");

    // A query over fewer than two vertices goes straight to done as inside.
    assert property (@(posedge clk) disable iff (!rst_n)
        query_accept && short_query |=> state_reg == picp_pkg::ST_DONE && inside_acc_reg)
        else $error("short query not reported as inside");

endmodule

// ===== design/picp_edge_unit.sv =====
// Pipelined edge test: sign of cross(B - A, P - A), one edge per cycle.
`timescale 1ns / 1ps

module picp_edge_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  picp_pkg::edge_ctl_t                    ctl,
    input  picp_pkg::vertex_t                      vert_a,
    input  picp_pkg::vertex_t                      vert_b,
    input  logic signed [picp_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [picp_pkg::COORD_WIDTH-1:0] point_y,
    output picp_pkg::edge_res_t                    res
);

    localparam int DW = picp_pkg::DIFF_WIDTH;
    localparam int PW = picp_pkg::PROD_WIDTH;

    picp_pkg::edge_ctl_t   s1_ctl_reg;
    picp_pkg::edge_ctl_t   s2_ctl_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg, tx_reg, ty_reg;
    logic signed [DW-1:0]  dx_next, dy_next, tx_next, ty_next;
    logic signed [PW-1:0]  p1_reg, p2_reg;
    logic signed [PW-1:0]  p1_next, p2_next;

    always_comb
    begin
        dx_next = DW'(vert_b.x) - DW'(vert_a.x);
        dy_next = DW'(vert_b.y) - DW'(vert_a.y);
        tx_next = DW'(point_x) - DW'(vert_a.x);
        ty_next = DW'(point_y) - DW'(vert_a.y);
        p1_next = PW'(dx_reg) * PW'(ty_reg);
        p2_next = PW'(dy_reg) * PW'(tx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
    end

    // The point lies on the outer side of the edge when dx*ty < dy*tx.
    always_comb
    begin
        res.valid = s2_ctl_reg.valid;
        res.last  = s2_ctl_reg.last;
        res.neg   = (p1_reg < p2_reg);
    end

endmodule
